// File: hw/rtl/cwc_pkg.sv
// Shared types, codes and constants for the congestion window controller.
// No dependencies; imported by cwc_update and congestion_window_controller.
package cwc_pkg;

  // Event kinds carried on the input channel's tuser.
  typedef enum logic [1:0] {
    OP_NEW_ACK = 2'd0,
    OP_DUP_ACK = 2'd1,
    OP_TIMEOUT = 2'd2,
    OP_SEND    = 2'd3
  } cwc_op_t;

  // Phase reported with every result.
  typedef enum logic [2:0] {
    PH_NONE       = 3'd0,
    PH_SLOW_START = 3'd1,
    PH_AVOID      = 3'd2,
    PH_FAST_RETX  = 3'd3,
    PH_TIMEOUT    = 3'd4
  } cwc_phase_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DUP_ACK_THRESHOLD = 2'd0,
    CFG_INITIAL_CWND      = 2'd1,
    CFG_INITIAL_SSTHRESH  = 2'd2,
    CFG_WINDOW_SIZE       = 2'd3
  } cwc_cfg_idx_t;

  localparam logic [15:0] CNT_MAX          = 16'hFFFF;
  localparam logic [3:0]  DUP_MAX          = 4'd15;
  localparam logic [3:0]  RST_DUP_ACK_THR  = 4'd3;
  localparam logic [15:0] RST_CWND         = 16'd1;
  localparam logic [15:0] RST_SSTHRESH     = 16'd64;
  localparam logic [15:0] RST_WINDOW_SIZE  = 16'd64;

  typedef struct packed {
    logic [15:0] window;
    logic [15:0] threshold;
    logic [15:0] unacked;
    logic [15:0] avoid_credit;
    logic [3:0]  dup_count;
  } cwc_state_t;

  typedef struct packed {
    cwc_op_t     op;
    logic [15:0] acked_count;
    logic [15:0] buffered_count;
  } cwc_item_t;

  typedef struct packed {
    logic [3:0]  dup_ack_threshold;
    logic [15:0] window_size;
  } cwc_cfg_t;

  typedef struct packed {
    logic [15:0] send_count;
    logic [15:0] first_index;
    logic        retransmit;
    logic [15:0] window_now;
    logic [15:0] threshold_now;
    logic [15:0] outstanding;
    cwc_phase_t  phase;
  } cwc_result_t;

  // Zero is not a legal window or threshold; it is read as one.
  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

// File: hw/rtl/cwc_update.sv
// Combinational state update for one congestion control event.
// Depends on cwc_pkg for the state, item, configuration and result types.
module cwc_update import cwc_pkg::*; (
  input  cwc_state_t  st,
  input  cwc_item_t   item,
  input  cwc_cfg_t    cfg,
  output cwc_state_t  st_nxt,
  output cwc_result_t res
);

  logic [16:0] ss_sum;
  logic [16:0] credit_sum;
  logic [15:0] credit_sat;
  logic [15:0] halved;
  logic [15:0] buf_lim;
  logic [15:0] limit;
  logic [3:0]  dup_inc;

  assign ss_sum     = {1'b0, st.window} + {1'b0, item.acked_count};
  assign credit_sum = {1'b0, st.avoid_credit} + {1'b0, item.acked_count};
  assign credit_sat = credit_sum[16] ? CNT_MAX : credit_sum[15:0];
  assign halved     = {1'b0, st.window[15:1]};
  assign buf_lim    = (item.buffered_count < cfg.window_size) ?
                      item.buffered_count : cfg.window_size;
  assign limit      = (st.window < buf_lim) ? st.window : buf_lim;
  assign dup_inc    = (st.dup_count < DUP_MAX) ? st.dup_count + 4'd1 : DUP_MAX;

  always_comb begin
    st_nxt          = st;
    res.send_count  = 16'd0;
    res.first_index = 16'd0;
    res.retransmit  = 1'b0;
    res.phase       = PH_NONE;

    unique case (item.op)
      OP_NEW_ACK: begin
        st_nxt.unacked   = (item.acked_count >= st.unacked) ?
                           16'd0 : st.unacked - item.acked_count;
        st_nxt.dup_count = 4'd0;
        if (st.window < st.threshold) begin
          if (ss_sum < {1'b0, st.threshold}) begin
            st_nxt.window = ss_sum[15:0];
          end else begin
            st_nxt.window       = st.threshold;
            st_nxt.avoid_credit = 16'd0;
          end
          res.phase = PH_SLOW_START;
        end else begin
          if (credit_sat >= st.window) begin
            st_nxt.window       = (st.window != CNT_MAX) ? st.window + 16'd1 : st.window;
            st_nxt.avoid_credit = 16'd0;
          end else begin
            st_nxt.avoid_credit = credit_sat;
          end
          res.phase = PH_AVOID;
        end
      end
      OP_DUP_ACK: begin
        if (dup_inc >= cfg.dup_ack_threshold) begin
          st_nxt.dup_count = 4'd0;
          st_nxt.unacked   = 16'd0;
          st_nxt.window    = (st.window > 16'd1) ? halved : st.window;
          st_nxt.threshold = (st.window > 16'd1) ? halved : st.window;
          res.retransmit   = 1'b1;
          res.phase        = PH_FAST_RETX;
        end else begin
          st_nxt.dup_count = dup_inc;
        end
      end
      OP_TIMEOUT: begin
        st_nxt.threshold = at_least_one(halved);
        st_nxt.window    = 16'd1;
        st_nxt.unacked   = 16'd0;
        st_nxt.dup_count = 4'd0;
        res.retransmit   = 1'b1;
        res.phase        = PH_TIMEOUT;
      end
      OP_SEND: begin
        res.first_index = st.unacked;
        if (st.unacked < limit) begin
          res.send_count = limit - st.unacked;
          st_nxt.unacked = limit;
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase

    res.window_now    = st_nxt.window;
    res.threshold_now = st_nxt.threshold;
    res.outstanding   = st_nxt.unacked;
  end

endmodule

// File: hw/rtl/congestion_window_controller.sv
// Top level of the sender-side congestion window controller.
// Depends on cwc_pkg and instantiates cwc_update.
//
// Usage:
//   Events enter on the in_ stream: in_tuser carries the event kind (new ACK,
//   duplicate ACK, retransmit timeout, send request) and in_tdata the acked
//   and buffered packet counts. Every event produces exactly one result on
//   the out_ stream with the grant, the window, the threshold, the packets in
//   flight after the event, and the phase it set, if any.
//   A request is captured in an input register, then one pass of
//   combinational update logic writes the controller state and the output
//   register in the same cycle, and out_tvalid rises with that write. One
//   request per cycle is sustained while the receiver takes results: the
//   update of the five state registers is the only loop, and it closes
//   through the combinational update logic alone.
//   When the receiver stalls, the result stays in the output register and
//   the input register still takes one more request; in_tready drops only
//   when both are full, so nothing is lost or repeated.
//   Reset (rst_n low at a clock edge) empties both registers, loads the
//   window with 1, the threshold with 64, clears in-flight, credit and the
//   duplicate count, and restores the register defaults. Writing
//   initial_cwnd or initial_ssthresh also loads the live window or threshold;
//   the user writes configuration only while the block is idle (unenforced).
module congestion_window_controller import cwc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Event stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // acked_count[15:0], buffered_count[31:16]
  input  logic [1:0]  in_tuser,   // op[1:0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // send_count[15:0], first_index[31:16], window_now[47:32],
  // threshold_now[63:48], outstanding[79:64]
  output logic [79:0] out_tdata,
  output logic [3:0]  out_tuser   // retransmit[0], phase[3:1]
);

  logic        in_valid_r, in_valid_nxt;
  cwc_item_t   in_item_r;
  logic        out_valid_r, out_valid_nxt;
  cwc_result_t out_res_r;
  cwc_state_t  st_r, st_nxt, upd_st;
  cwc_cfg_t    cfg_r, cfg_nxt;
  cwc_result_t upd_res;
  logic        in_take;
  logic        advance;

  // A held request moves on whenever the output register is free or drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && !out_tready);

  cwc_update u_update (
    .st     (st_r),
    .item   (in_item_r),
    .cfg    (cfg_r),
    .st_nxt (upd_st),
    .res    (upd_res)
  );

  // Configuration writes land in the register file and, for the initial
  // values, also in the live window and threshold.
  always_comb begin
    cfg_nxt = cfg_r;
    st_nxt  = advance ? upd_st : st_r;
    if (cfg_we) begin
      unique case (cwc_cfg_idx_t'(cfg_index))
        CFG_DUP_ACK_THRESHOLD: cfg_nxt.dup_ack_threshold = cfg_wdata[3:0];
        CFG_INITIAL_CWND:      st_nxt.window    = at_least_one(cfg_wdata);
        CFG_INITIAL_SSTHRESH:  st_nxt.threshold = at_least_one(cfg_wdata);
        CFG_WINDOW_SIZE:       cfg_nxt.window_size = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r              <= 1'b0;
      out_valid_r             <= 1'b0;
      st_r.window             <= RST_CWND;
      st_r.threshold          <= RST_SSTHRESH;
      st_r.unacked            <= 16'd0;
      st_r.avoid_credit       <= 16'd0;
      st_r.dup_count          <= 4'd0;
      cfg_r.dup_ack_threshold <= RST_DUP_ACK_THR;
      cfg_r.window_size       <= RST_WINDOW_SIZE;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      cfg_r       <= cfg_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_item_r.op             <= cwc_op_t'(in_tuser);
      in_item_r.acked_count    <= in_tdata[15:0];
      in_item_r.buffered_count <= in_tdata[31:16];
    end
    if (advance) begin
      out_res_r <= upd_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.outstanding, out_res_r.threshold_now,
                       out_res_r.window_now, out_res_r.first_index,
                       out_res_r.send_count};
  assign out_tuser  = {out_res_r.phase, out_res_r.retransmit};

  // The window and threshold are never zero.
  a_window_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.window != 16'd0)
    else $error("window register reached zero");

  a_threshold_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.threshold != 16'd0)
    else $error("threshold register reached zero");

  // A retransmit restarts from the oldest packet, so nothing stays in flight.
  a_retx_clears_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.retransmit |-> out_res_r.outstanding == 16'd0)
    else $error("retransmit result with packets still in flight");

  // A grant never takes the packets in flight past the window.
  a_grant_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.send_count != 16'd0 |->
      out_res_r.outstanding <= out_res_r.window_now)
    else $error("grant exceeds the congestion window");

endmodule
